>>> rtl/core/stable_key_value_merge_sort_assert.svh
// Assertion macros used by the checker of the sorter.
`ifndef STABLE_KEY_VALUE_MERGE_SORT_ASSERT_SVH
`define STABLE_KEY_VALUE_MERGE_SORT_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define SKVMS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define SKVMS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/skvms_pkg.sv
`default_nettype none

package skvms_pkg;

   // Width of a key and of a value.
   localparam int DATA_W = 32;

   // Default number of pairs that one set may hold.
   localparam int DEFAULT_CAPACITY = 64;

   // One stored pair, key in the upper half.
   typedef struct packed {
      logic signed [DATA_W-1:0] key;
      logic signed [DATA_W-1:0] value;
   } pair_type;

   // Sequencer states: load, merge passes, then output.
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PASS_CHECK,
      ST_SETUP,
      ST_MERGE_READ,
      ST_MERGE_WRITE,
      ST_OUT_READ,
      ST_OUT_CAPTURE,
      ST_OUT_HOLD
   } state_type;

endpackage

`default_nettype wire

>>> rtl/core/skvms_pair_ram.sv
`default_nettype none

// Pair memory with one write port and two read ports, read data registered.
module skvms_pair_ram
   import skvms_pkg::*;
#(
   parameter int DEPTH = 2 * DEFAULT_CAPACITY,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire pair_type      wr_data,
   input  wire logic [AW-1:0] rd_a_addr,
   input  wire logic [AW-1:0] rd_b_addr,
   output pair_type           rd_a_data,
   output pair_type           rd_b_data
);

   pair_type mem_ff [DEPTH];
   pair_type rd_a_ff;
   pair_type rd_b_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Two registered read ports.
   always_ff @(posedge clock) begin
      rd_a_ff <= mem_ff[rd_a_addr];
      rd_b_ff <= mem_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

`default_nettype wire

>>> rtl/core/stable_key_value_merge_sort.sv
// Loading accepts one word per cycle; the word marked last closes the set.
// Sorting runs ceil(log2 n) bottom-up merge passes over a two-bank pair memory;
// each element of a pass goes through a read state and a write state, each merged
// block through a setup state and each pass through a check state.
// Each output word passes through a read, a capture and a hold state, and is held until the receiver takes it.
// Synchronous reset empties the set and idles the block in the load state.
`default_nettype none

module stable_key_value_merge_sort
   import skvms_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic signed [DATA_W-1:0] req_item_key,
   input  wire logic signed [DATA_W-1:0] req_item_value,
   input  wire logic                     req_item_last,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [DATA_W-1:0]      rsp_sorted_key,
   output logic signed [DATA_W-1:0]      rsp_sorted_value,
   output logic                          rsp_run_last,
   output logic                          rsp_dropped_flag
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int WW = CW + 1;
   localparam int SW = CW + 2;
   localparam int AW = IW + 1;

   state_type     state_ff, state_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic          overflow_ff, overflow_in;
   logic          src_ff, src_in;
   logic [WW-1:0] width_ff, width_in;
   logic [CW-1:0] k_ff, k_in;
   logic [CW-1:0] li_ff, li_in;
   logic [CW-1:0] lend_ff, lend_in;
   logic [CW-1:0] ri_ff, ri_in;
   logic [CW-1:0] rend_ff, rend_in;
   logic          rsp_valid_ff, rsp_valid_in;
   pair_type      rsp_pair_ff, rsp_pair_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_drop_ff, rsp_drop_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   pair_type      wr_data;
   logic [AW-1:0] rd_a_addr;
   logic [AW-1:0] rd_b_addr;
   pair_type      rd_a_data;
   pair_type      rd_b_data;

   logic          full;
   logic          req_take;
   logic [CW-1:0] k_next;
   logic [SW-1:0] sum_left;
   logic [SW-1:0] sum_right;
   logic          left_ok;
   logic          right_ok;
   logic          take_left;

   // Each bank spans the full index range, so the bank bit sits above it.
   skvms_pair_ram #(
      .DEPTH (2 ** AW),
      .AW    (AW)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   // Helpers for loading and merging.
   assign full      = (fill_ff == CW'(CAPACITY));
   assign req_take  = req_valid && !req_stall;
   assign k_next    = k_ff + 1'b1;
   assign sum_left  = SW'(k_ff) + SW'(width_ff);
   assign sum_right = sum_left + SW'(width_ff);
   assign left_ok   = (li_ff != lend_ff);
   assign right_ok  = (ri_ff != rend_ff);
   // On equal keys the left run, which arrived earlier, wins.
   assign take_left = left_ok && (!right_ok || !(rd_a_data.key > rd_b_data.key));

   // State and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         fill_ff      <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Pointers and output word need no reset.
   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      width_ff    <= width_in;
      k_ff        <= k_in;
      li_ff       <= li_in;
      lend_ff     <= lend_in;
      ri_ff       <= ri_in;
      rend_ff     <= rend_in;
      rsp_pair_ff <= rsp_pair_in;
      rsp_last_ff <= rsp_last_in;
      rsp_drop_ff <= rsp_drop_in;
   end

   // Sequencer: next state, memory accesses and pointer updates.
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      overflow_in  = overflow_ff;
      src_in       = src_ff;
      width_in     = width_ff;
      k_in         = k_ff;
      li_in        = li_ff;
      lend_in      = lend_ff;
      ri_in        = ri_ff;
      rend_in      = rend_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pair_in  = rsp_pair_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_drop_in  = rsp_drop_ff;
      wr_en        = 1'b0;
      wr_addr      = {1'b0, fill_ff[IW-1:0]};
      wr_data      = '{key: req_item_key, value: req_item_value};
      rd_a_addr    = {src_ff, li_ff[IW-1:0]};
      rd_b_addr    = {src_ff, ri_ff[IW-1:0]};
      req_stall    = (state_ff != ST_LOAD);

      unique case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               if (full) begin
                  overflow_in = 1'b1;
               end else begin
                  wr_en   = 1'b1;
                  fill_in = fill_ff + 1'b1;
               end
               if (req_item_last) begin
                  width_in = WW'(1);
                  src_in   = 1'b0;
                  state_in = ST_PASS_CHECK;
               end
            end
         end

         // A pass is needed while the run width is below the set size.
         ST_PASS_CHECK: begin
            k_in = '0;
            if (width_ff >= WW'(fill_ff)) begin
               state_in = ST_OUT_READ;
            end else begin
               state_in = ST_SETUP;
            end
         end

         // Bounds of the two runs that start at the current write position.
         ST_SETUP: begin
            li_in   = k_ff;
            lend_in = (sum_left < SW'(fill_ff)) ? sum_left[CW-1:0] : fill_ff;
            ri_in   = (sum_left < SW'(fill_ff)) ? sum_left[CW-1:0] : fill_ff;
            rend_in = (sum_right < SW'(fill_ff)) ? sum_right[CW-1:0] : fill_ff;
            state_in = ST_MERGE_READ;
         end

         // Fetch both run heads from the source bank.
         ST_MERGE_READ: begin
            state_in = ST_MERGE_WRITE;
         end

         // Write the smaller head into the other bank.
         ST_MERGE_WRITE: begin
            wr_en   = 1'b1;
            wr_addr = {~src_ff, k_ff[IW-1:0]};
            wr_data = take_left ? rd_a_data : rd_b_data;
            if (take_left) begin
               li_in = li_ff + 1'b1;
            end else begin
               ri_in = ri_ff + 1'b1;
            end
            k_in = k_next;
            if (k_next == fill_ff) begin
               src_in   = ~src_ff;
               width_in = {width_ff[WW-2:0], 1'b0};
               state_in = ST_PASS_CHECK;
            end else if (k_next == rend_ff) begin
               state_in = ST_SETUP;
            end else begin
               state_in = ST_MERGE_READ;
            end
         end

         ST_OUT_READ: begin
            rd_a_addr = {src_ff, k_ff[IW-1:0]};
            state_in  = ST_OUT_CAPTURE;
         end

         ST_OUT_CAPTURE: begin
            rsp_pair_in  = rd_a_data;
            rsp_last_in  = (k_next == fill_ff);
            rsp_drop_in  = overflow_ff;
            rsp_valid_in = 1'b1;
            state_in     = ST_OUT_HOLD;
         end

         // Hold the word until the receiver takes it.
         ST_OUT_HOLD: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  fill_in     = '0;
                  overflow_in = 1'b0;
                  state_in    = ST_LOAD;
               end else begin
                  k_in     = k_next;
                  state_in = ST_OUT_READ;
               end
            end
         end

         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_key   = rsp_pair_ff.key;
   assign rsp_sorted_value = rsp_pair_ff.value;
   assign rsp_run_last     = rsp_last_ff;
   assign rsp_dropped_flag = rsp_drop_ff;

endmodule

`default_nettype wire

>>> rtl/core/skvms_checker.sv
`default_nettype none

`include "stable_key_value_merge_sort_assert.svh"

// Port-level checks of the sorter.
module skvms_checker
   import skvms_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_stall,
   input wire logic signed [DATA_W-1:0] req_item_key,
   input wire logic signed [DATA_W-1:0] req_item_value,
   input wire logic                     req_item_last,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire logic signed [DATA_W-1:0] rsp_sorted_key,
   input wire logic signed [DATA_W-1:0] rsp_sorted_value,
   input wire logic                     rsp_run_last,
   input wire logic                     rsp_dropped_flag
);

   logic       req_take;
   logic       rsp_take;
   logic [1:0] rsp_word;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;
   assign rsp_word = {rsp_run_last, rsp_dropped_flag};

   // A stalled result word is held unchanged.
   `SKVMS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_sorted_key) && $stable(rsp_sorted_value) && $stable(rsp_word),
      "stalled result word changed")

   // No pair is taken in while results are being delivered.
   `SKVMS_ASSERT_NOW(a_no_load_in_output, clock, reset, rsp_valid, req_stall,
      "input accepted while a result is pending")

   // The input is closed once the last pair of a set is taken.
   `SKVMS_ASSERT_NEXT(a_last_closes_input, clock, reset, req_take && req_item_last, req_stall,
      "input still open after the last pair")

   // Output stops after the final word of a set.
   `SKVMS_ASSERT_NEXT(a_run_ends, clock, reset, rsp_take && rsp_run_last, !rsp_valid,
      "result shown after the final word")

endmodule

bind stable_key_value_merge_sort skvms_checker u_checker (.*);

`default_nettype wire
